// File: hdl/rdc_pkg.sv
// ---------------------------------------------------------------------------
// Radix digit converter package
// Shared types, constants and helpers for the radix digit converter.
// ---------------------------------------------------------------------------
package rdc_pkg;

    localparam int DIGIT_W     = 4;
    localparam int SLICE_BITS  = 8;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 4'd9;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOAD,
        ST_OUT
    } rdc_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } rdc_stack_ctl_t;

    function automatic logic [DIGIT_W-1:0] sat_radix(input logic [DIGIT_W-1:0] radix);
        logic [DIGIT_W-1:0] res;
        res = radix;
        if (radix < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

// File: hdl/rdc_div_slice.sv
// ---------------------------------------------------------------------------
// Radix digit converter division slice
// Divides one byte of the running quotient by the radix, carrying the
// partial remainder in from the more significant bytes.
// ---------------------------------------------------------------------------
module rdc_div_slice (
    input  logic [3:0] rem_in,
    input  logic [7:0] bits_in,
    input  logic [3:0] divisor,
    output logic [3:0] rem_out,
    output logic [7:0] quot_out
);
    import rdc_pkg::*;

    always_comb begin
        logic [DIGIT_W-1:0] r;
        logic [DIGIT_W:0]   t;
        r        = rem_in;
        t        = '0;
        quot_out = '0;
        for (int i = SLICE_BITS - 1; i >= 0; i--) begin
            t = {r, bits_in[i]};
            if (t >= {1'b0, divisor}) begin
                r           = DIGIT_W'(t - {1'b0, divisor});
                quot_out[i] = 1'b1;
            end else begin
                r = t[DIGIT_W-1:0];
            end
        end
        rem_out = r;
    end

endmodule

// File: hdl/rdc_digit_stack.sv
// ---------------------------------------------------------------------------
// Radix digit converter digit stack
// Single write port, single registered read port digit memory.
// ---------------------------------------------------------------------------
module rdc_digit_stack #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  rdc_pkg::rdc_stack_ctl_t       ctl,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [rdc_pkg::DIGIT_W-1:0]   wr_data,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [rdc_pkg::DIGIT_W-1:0]   rd_data
);
    import rdc_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/radix_digit_converter.sv
// ---------------------------------------------------------------------------
// Radix digit converter
// Converts an unsigned number into digits of radix two to nine by repeated
// division, most significant digit first, last digit flagged on m_tlast.
// Each digit passes every byte of the quotient, most significant first,
// through the shared byte divider and is pushed onto the digit stack.
// Once all digits are found, the load state reads the top of the stack and
// the digits then follow one per cycle while m_tready is high.
// The next request is taken the cycle after the last digit is delivered.
// Reset is synchronous, active low; radix returns to 8, no stack clearing.
// ---------------------------------------------------------------------------
module radix_digit_converter #(
    parameter int VALUE_WIDTH = 32,
    parameter int STACK_DEPTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,   // value
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [3:0]                           cfg_data,  // radix
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // digit
    output logic                                 m_tlast
);
    import rdc_pkg::*;

    localparam int SLICES = (VALUE_WIDTH + SLICE_BITS - 1) / SLICE_BITS;
    localparam int QW     = SLICES * SLICE_BITS;
    localparam int SCW    = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int FW     = $clog2(STACK_DEPTH + 1);

    rdc_state_t         state_reg, state_next;
    logic [DIGIT_W-1:0] radix_reg, radix_next;
    logic [DIGIT_W-1:0] div_reg, div_next;
    logic [QW-1:0]      quot_reg, quot_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic               nz_reg, nz_next;
    logic [SCW-1:0]     slice_reg, slice_next;
    logic [FW-1:0]      fill_reg, fill_next;

    logic [DIGIT_W-1:0]    rem_step;
    logic [SLICE_BITS-1:0] qbits;
    logic [FW-1:0]         fill_minus;
    logic [DIGIT_W-1:0]    rd_data;
    rdc_stack_ctl_t        stack_ctl;

    assign fill_minus = fill_reg - 1'b1;

    rdc_div_slice u_div (
        .rem_in   (rem_reg),
        .bits_in  (quot_reg[QW-1 -: SLICE_BITS]),
        .divisor  (div_reg),
        .rem_out  (rem_step),
        .quot_out (qbits)
    );

    rdc_digit_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (aclk),
        .ctl     (stack_ctl),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (rem_step),
        .rd_addr (fill_minus[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_RESET;
            quot_reg  <= '0;
            rem_reg   <= '0;
            nz_reg    <= 1'b0;
            slice_reg <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            radix_reg <= radix_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
            nz_reg    <= nz_next;
            slice_reg <= slice_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
    end

    always_comb begin
        state_next = state_reg;
        radix_next = radix_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        nz_next    = nz_reg;
        slice_next = slice_reg;
        fill_next  = fill_reg;
        stack_ctl  = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cfg_ready  = aresetn;

        if (cfg_valid) begin
            radix_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    quot_next  = QW'(s_tdata[VALUE_WIDTH-1:0]);
                    rem_next   = '0;
                    nz_next    = 1'b0;
                    slice_next = '0;
                    fill_next  = '0;
                    div_next   = sat_radix(radix_reg);
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                quot_next  = (quot_reg << SLICE_BITS) | QW'(qbits);
                rem_next   = rem_step;
                nz_next    = nz_reg | (|qbits);
                slice_next = slice_reg + 1'b1;
                if (slice_reg == SCW'(SLICES - 1)) begin
                    stack_ctl.wr_en = 1'b1;
                    fill_next       = fill_reg + 1'b1;
                    rem_next        = '0;
                    nz_next         = 1'b0;
                    slice_next      = '0;
                    if (!((nz_reg | (|qbits)) && (fill_reg != FW'(STACK_DEPTH - 1)))) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                stack_ctl.rd_en = 1'b1;
                fill_next       = fill_minus;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (fill_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        stack_ctl.rd_en = 1'b1;
                        fill_next       = fill_minus;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {{(8 - DIGIT_W){1'b0}}, rd_data};
    assign m_tlast = (fill_reg == '0);

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new request taken while a conversion is in progress");

    a_digit_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rd_data < div_reg))
        else $error("output digit not below the radix");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(STACK_DEPTH))
        else $error("digit stack overfilled");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("converter not idle after the last digit");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Radix digit converter testbench
// Sends numbers to the converter and writes radix settings from every corner
// of the register, saturating values included. Each accepted request is
// expanded into its digit sequence by a predictor in the testbench. Every
// digit that comes out, with its last flag, is checked against the oldest
// expected digit. Both sides idle at random, and the digit receiver holds
// off once for a long stretch so that the converter stalls its input.
// ---------------------------------------------------------------------------
module tb_top;

    import rdc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_DIGITS  = 32;
    localparam int IDLE_PCT    = 11;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 200;

    typedef struct {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } digit_rec_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata   = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [3:0]          cfg_data  = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tlast;

    logic [31:0]         number_queue [$];
    digit_rec_t          digit_queue [$];
    logic [3:0]          radix_setting = RADIX_RESET;
    logic [3:0]          radix_plan [16];
    logic                number_taken   = 1'b0;
    int                  numbers_taken  = 0;
    int                  mismatches     = 0;
    int                  hold_left      = 0;
    logic                hold_done      = 1'b0;
    int                  cycle_count;

    radix_digit_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic void expand_digits(input logic [31:0] number, input logic [3:0] radix_reg);
        logic [3:0]  stack_buf [MAX_DIGITS];
        logic [31:0] quot;
        logic [3:0]  base;
        int          depth;
        digit_rec_t  rec;
        base = radix_reg;
        if (radix_reg < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        quot  = number;
        depth = 0;
        if (quot == 0) begin
            stack_buf[0] = '0;
            depth = 1;
        end
        while (quot != 0 && depth < MAX_DIGITS) begin
            stack_buf[depth] = 4'(quot % base);
            quot = quot / base;
            depth++;
        end
        for (int i = depth - 1; i >= 0; i--) begin
            rec.digit      = stack_buf[i];
            rec.last_digit = (i == 0);
            digit_queue.push_back(rec);
        end
    endfunction

    function automatic logic [31:0] random_number();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4:          return $urandom_range(99);
            5:          return $urandom >> $urandom_range(31);
            6:          return 32'hFFFF_FFFF - $urandom_range(3);
            7:          return 32'd1 << $urandom_range(31);
            8:          return (32'd1 << $urandom_range(31)) - 32'd1;
            default:    return '0;
        endcase
    endfunction

    function automatic logic quiet_stretch();
        return numbers_taken >= 60 && numbers_taken < 150;
    endfunction

    task automatic write_radix(input logic [3:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (number_queue.size() != 0 || digit_queue.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    // Request driver: an offered number stays on the bus until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || number_taken) begin
            if (number_queue.size() != 0 &&
                (quiet_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= number_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        number_taken = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && numbers_taken >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= hold_left == 0 && (quiet_stretch() || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Accepted requests, register writes and digit checks.
    always @(posedge aclk) begin
        digit_rec_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                radix_setting = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                expand_digits(s_tdata, radix_setting);
                void'(number_queue.pop_front());
                number_taken = 1'b1;
                numbers_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (digit_queue.size() == 0) begin
                    $error("digit: expected none, actual %0d", m_tdata);
                    mismatches++;
                end else begin
                    want = digit_queue.pop_front();
                    if (m_tdata !== 8'(want.digit)) begin
                        $error("digit: expected %0d, actual %0d", want.digit, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last_digit) begin
                        $error("last_digit: expected %0d, actual %0d", want.last_digit, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
            @(posedge aclk);
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        radix_plan = '{4'd2, 4'd9, 4'd0, 4'd15, 4'd1, 4'd10, 4'd5, 4'd3,
                       4'd4, 4'd6, 4'd7, 4'd8, 4'd11, 4'd12, 4'd13, 4'd14};
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset radix of eight, with the extremes of the number.
        number_queue = '{32'd0, 32'd1, 32'd7, 32'd8, 32'd9, 32'd63, 32'd64,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                         32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678};
        wait_drained();

        foreach (radix_plan[p]) begin
            write_radix(radix_plan[p]);
            repeat (31) number_queue.push_back(random_number());
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(negedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/rdc_pkg.sv
hdl/rdc_div_slice.sv
hdl/rdc_digit_stack.sv
hdl/radix_digit_converter.sv
tb/sv/tb_top.sv
